// ----- src/ppa_pkg.sv -----
package ppa_pkg;

    localparam int DEF_COLS = 8;
    localparam int DEF_ROWS = 8;
    localparam int PIX_W = 24;
    localparam int SUM_W = 32;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NEG = 3'd1;
    localparam logic [2:0] ST_X_RANGE = 3'd2;
    localparam logic [2:0] ST_Y_RANGE = 3'd3;
    localparam logic [2:0] ST_UNSET = 3'd4;

    localparam logic [1:0] REQ_ADD_POS = 2'd0;
    localparam logic [1:0] REQ_ADD_PIX = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_READ = 2'd3;

    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_INV_W = 3'd2;
    localparam logic [2:0] CFG_INV_H = 3'd3;
    localparam logic [2:0] CFG_KIND = 3'd4;

    localparam logic [1:0] KIND_NEUTRON = 2'd1;
    localparam logic [1:0] KIND_PROTON = 2'd2;

    typedef struct packed {
        logic [1:0] req;
        logic       neg;
        logic       okx;
        logic       oky;
        logic [5:0] col;
        logic [5:0] row;
        logic [15:0] photons;
    } cmd_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ----- src/ppa_ram.sv -----
module ppa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/ppa_front.sv -----
module ppa_front
    import ppa_pkg::*;
#(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [5:0]  pixel_col,
    input  logic [5:0]  pixel_row,
    input  logic [15:0] photons,
    input  logic [31:0] origin_x,
    input  logic [31:0] origin_y,
    input  logic [31:0] inv_w,
    input  logic [31:0] inv_h,
    output logic        out_valid,
    input  logic        out_ready,
    output cmd_t        out_cmd
);
    // stage 1: difference; stage 2: products; stage 3: range check
    logic        v1_reg, v2_reg, v3_reg;
    logic [1:0]  req1_reg, req2_reg;
    logic [15:0] ph1_reg, ph2_reg;
    logic [5:0]  pc1_reg, pr1_reg, pc2_reg, pr2_reg;
    logic [32:0] dx_reg, dy_reg;
    logic [31:0] ix1_reg, iy1_reg;
    logic [63:0] px_reg, py_reg;
    logic        nx_reg, ny_reg, zx_reg, zy_reg;
    cmd_t        cmd_reg;
    logic        adv3, adv2, adv1;
    logic        okx, oky;
    logic [5:0]  col, row;

    assign adv3 = !v3_reg || out_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ready = adv1;
    assign out_valid = v3_reg;
    assign out_cmd = cmd_reg;

    always_comb
    begin
        okx = 1'b0;
        oky = 1'b0;
        col = '0;
        row = '0;
        if (req2_reg == REQ_ADD_POS)
        begin
            if (nx_reg)
            begin
                okx = zx_reg;
            end
            else
            begin
                okx = px_reg[63:32] < 32'(COLS);
                col = px_reg[37:32];
            end
            if (ny_reg)
            begin
                oky = zy_reg;
            end
            else
            begin
                oky = py_reg[63:32] < 32'(ROWS);
                row = py_reg[37:32];
            end
        end
        else
        begin
            col = pc2_reg;
            row = pr2_reg;
            okx = 32'(pc2_reg) < 32'(COLS);
            oky = 32'(pr2_reg) < 32'(ROWS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            req1_reg <= req_type;
            ph1_reg <= photons;
            pc1_reg <= pixel_col;
            pr1_reg <= pixel_row;
            dx_reg <= {pos_x[31], pos_x} - {origin_x[31], origin_x};
            dy_reg <= {pos_y[31], pos_y} - {origin_y[31], origin_y};
            ix1_reg <= inv_w;
            iy1_reg <= inv_h;
        end
        if (adv2)
        begin
            req2_reg <= req1_reg;
            ph2_reg <= ph1_reg;
            pc2_reg <= pc1_reg;
            pr2_reg <= pr1_reg;
            px_reg <= 64'(dx_reg[31:0]) * 64'(ix1_reg);
            py_reg <= 64'(dy_reg[31:0]) * 64'(iy1_reg);
            nx_reg <= dx_reg[32];
            ny_reg <= dy_reg[32];
            zx_reg <= ix1_reg == '0;
            zy_reg <= iy1_reg == '0;
        end
        if (adv3)
        begin
            cmd_reg.req <= req2_reg;
            cmd_reg.neg <= ph2_reg[15];
            cmd_reg.okx <= okx;
            cmd_reg.oky <= oky;
            cmd_reg.col <= col;
            cmd_reg.row <= row;
            cmd_reg.photons <= ph2_reg;
        end
    end
endmodule

// ----- src/ppa_fifo.sv -----
module ppa_fifo
    import ppa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);
    cmd_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_cmd = q_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wp_reg] <= in_cmd;
        end
    end
endmodule

// ----- src/ppa_back.sv -----
module ppa_back
    import ppa_pkg::*;
#(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cmd_t        in_cmd,
    input  logic [1:0]  kind,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  status,
    output logic [31:0] sum_common,
    output logic [31:0] sum_ch1,
    output logic [31:0] sum_ch2,
    output logic [31:0] sum_ch3,
    output logic [31:0] sum_ch4,
    output logic [31:0] total_photons
);
    localparam int NPIX = COLS * ROWS;
    localparam int AW = $clog2(NPIX);
    localparam int CW = $clog2(COLS);
    localparam int RW = $clog2(ROWS);

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RMW   = 5'b00100,
        S_CLEAR = 5'b01000,
        S_READ  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [AW:0] addr_reg;
    logic [CW-1:0] wc_reg, rc_reg;
    logic [RW-1:0] wr_reg, rr_reg;
    logic        rv_reg;
    logic [31:0] total_reg;
    logic [31:0] sums_reg [5];
    logic [15:0] ph_reg;
    logic [AW-1:0] k_reg;
    logic        ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [PIX_W-1:0] ram_wdata, ram_rdata;
    logic [PIX_W:0] psum;
    logic        out_full_reg;
    logic [2:0]  st_reg;
    logic [31:0] o_sums_reg [5];
    logic [31:0] o_total_reg;
    logic        emit;
    logic [2:0]  emit_st;
    logic        emit_sums;
    logic [2:0]  ch;
    logic [AW-1:0] k_in;

    assign k_in = AW'(32'(in_cmd.col) * ROWS + 32'(in_cmd.row));
    assign psum = {1'b0, ram_rdata} + (PIX_W+1)'(ph_reg);
    assign in_ready = (state_reg == S_IDLE) && !out_full_reg;
    assign res_valid = out_full_reg;
    assign status = st_reg;
    assign sum_common = o_sums_reg[0];
    assign sum_ch1 = o_sums_reg[1];
    assign sum_ch2 = o_sums_reg[2];
    assign sum_ch3 = o_sums_reg[3];
    assign sum_ch4 = o_sums_reg[4];
    assign total_photons = o_total_reg;

    always_comb
    begin
        ch = 3'd0;
        if (rc_reg[0] ^ rr_reg[0])
        begin
            if (kind == KIND_NEUTRON)
            begin
                if (32'(rc_reg) < COLS / 2)
                begin
                    ch = (32'(rr_reg) < ROWS / 2) ? 3'd1 : 3'd3;
                end
                else
                begin
                    ch = (32'(rr_reg) >= ROWS / 2) ? 3'd4 : 3'd2;
                end
            end
            else
            begin
                if ((32'(rc_reg) << 2) >= 32'(3 * COLS))
                begin
                    ch = 3'd4;
                end
                else if ((32'(rc_reg) << 2) >= 32'(2 * COLS))
                begin
                    ch = 3'd3;
                end
                else if ((32'(rc_reg) << 2) >= 32'(COLS))
                begin
                    ch = 3'd2;
                end
                else
                begin
                    ch = 3'd1;
                end
            end
        end
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = k_reg;
        ram_wdata = psum[PIX_W] ? {PIX_W{1'b1}} : psum[PIX_W-1:0];
        ram_raddr = k_in;
        state_next = state_reg;
        emit = 1'b0;
        emit_st = ST_OK;
        emit_sums = 1'b0;
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_we = 1'b1;
                ram_waddr = addr_reg[AW-1:0];
                ram_wdata = '0;
                if (32'(addr_reg) == NPIX - 1)
                begin
                    state_next = S_IDLE;
                    emit = state_reg == S_CLEAR;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (in_cmd.req)
                        REQ_ADD_POS, REQ_ADD_PIX:
                        begin
                            if (in_cmd.neg || !in_cmd.okx || !in_cmd.oky)
                            begin
                                emit = 1'b1;
                                emit_st = in_cmd.neg ? ST_NEG
                                        : (!in_cmd.okx ? ST_X_RANGE : ST_Y_RANGE);
                            end
                            else
                            begin
                                state_next = S_RMW;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            if (total_reg == '0)
                            begin
                                emit = 1'b1;
                            end
                            else if (kind != KIND_NEUTRON && kind != KIND_PROTON)
                            begin
                                emit = 1'b1;
                                emit_st = ST_UNSET;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_RMW:
            begin
                ram_we = 1'b1;
                emit = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                ram_raddr = addr_reg[AW-1:0];
                if (rv_reg && 32'(addr_reg) == NPIX)
                begin
                    state_next = S_IDLE;
                    emit = 1'b1;
                    emit_sums = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            addr_reg <= '0;
            total_reg <= '0;
            out_full_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_full_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_full_reg <= 1'b0;
            end
            rv_reg <= 1'b0;
            case (state_reg)
                S_INIT, S_CLEAR:
                begin
                    addr_reg <= (32'(addr_reg) == NPIX - 1) ? '0 : addr_reg + 1'b1;
                    if (state_reg == S_CLEAR)
                    begin
                        total_reg <= '0;
                    end
                end
                S_RMW:
                begin
                    total_reg <= sat_add32(total_reg, 32'(ph_reg));
                end
                S_READ:
                begin
                    if (32'(addr_reg) == NPIX)
                    begin
                        if (rv_reg)
                        begin
                            addr_reg <= '0;
                        end
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                        rv_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            k_reg <= k_in;
            ph_reg <= in_cmd.photons;
            for (int i = 0; i < 5; i++)
            begin
                sums_reg[i] <= '0;
            end
            rc_reg <= '0;
            rr_reg <= '0;
            wc_reg <= '0;
            wr_reg <= '0;
        end
        else if (state_reg == S_READ)
        begin
            // pipeline: address issued now; data back next cycle
            if (32'(addr_reg) != NPIX)
            begin
                rc_reg <= wc_reg;
                rr_reg <= wr_reg;
                if (32'(wr_reg) == ROWS - 1)
                begin
                    wr_reg <= '0;
                    wc_reg <= wc_reg + 1'b1;
                end
                else
                begin
                    wr_reg <= wr_reg + 1'b1;
                end
            end
            if (rv_reg)
            begin
                sums_reg[ch] <= sat_add32(sums_reg[ch], 32'(ram_rdata));
            end
        end
        if (emit)
        begin
            st_reg <= emit_st;
            for (int i = 0; i < 5; i++)
            begin
                o_sums_reg[i] <= !emit_sums ? '0
                               : (3'(i) == ch) ? sat_add32(sums_reg[i], 32'(ram_rdata))
                               : sums_reg[i];
            end
            o_total_reg <= (state_reg == S_CLEAR) ? '0
                         : (state_reg == S_RMW) ? sat_add32(total_reg, 32'(ph_reg))
                         : total_reg;
        end
    end

    ppa_ram #(
        .WIDTH(PIX_W),
        .DEPTH(NPIX)
    ) u_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );
endmodule

// ----- src/photon_pixel_accumulator_core.sv -----
// Photon pixel accumulator: COLS x ROWS image of photon counts and total.
// Input queue: drive the request fields with push; the item is taken at a
// clock edge with push high and full low. Results: while empty is low the
// oldest result is on the result ports; pop takes it. One result per item.
// Configuration: write wr_en/wr_index/wr_data while the block is idle.
// Path: a valid add passes three front stages for the Q16.16 position
// multiply and range check, the queue, then a back-end read and a write;
// a rejected add or a read of an empty image is answered without the
// read and the write. Clear and a full read walk all COLS*ROWS pixels.
// The back end takes the next item only once the output register has
// drained, even with pop held high.
// Reset clears the state registers and runs a clearing pass over all
// COLS*ROWS pixels of the pixel memory before items are taken.
// When the receiver stalls, the output register holds the result and the
// back end stops; the queue and front stages fill, then full rises.
module photon_pixel_accumulator_core
    import ppa_pkg::*;
#(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [5:0]  pixel_col,
    input  logic [5:0]  pixel_row,
    input  logic [15:0] photons,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [31:0] sum_common,
    output logic [31:0] sum_ch1,
    output logic [31:0] sum_ch2,
    output logic [31:0] sum_ch3,
    output logic [31:0] sum_ch4,
    output logic [31:0] total_photons,
    input  logic        wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);
    logic [31:0] origin_x_reg, origin_y_reg, inv_w_reg, inv_h_reg;
    logic [1:0]  kind_reg;
    logic        in_ready, f_valid, f_ready, q_valid, q_ready, res_valid;
    cmd_t        f_cmd, q_cmd;

    assign full = !in_ready;
    assign empty = !res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            inv_w_reg <= 32'd65536;
            inv_h_reg <= 32'd65536;
            kind_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_ORIGIN_X: origin_x_reg <= wr_data;
                CFG_ORIGIN_Y: origin_y_reg <= wr_data;
                CFG_INV_W:    inv_w_reg <= wr_data;
                CFG_INV_H:    inv_h_reg <= wr_data;
                CFG_KIND:     kind_reg <= wr_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    ppa_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(push), .in_ready(in_ready),
        .req_type(req_type), .pos_x(pos_x), .pos_y(pos_y),
        .pixel_col(pixel_col), .pixel_row(pixel_row), .photons(photons),
        .origin_x(origin_x_reg), .origin_y(origin_y_reg),
        .inv_w(inv_w_reg), .inv_h(inv_h_reg),
        .out_valid(f_valid), .out_ready(f_ready), .out_cmd(f_cmd)
    );

    ppa_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    ppa_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_cmd(q_cmd),
        .kind(kind_reg),
        .res_valid(res_valid), .res_ready(pop),
        .status(status), .sum_common(sum_common), .sum_ch1(sum_ch1),
        .sum_ch2(sum_ch2), .sum_ch3(sum_ch3), .sum_ch4(sum_ch4),
        .total_photons(total_photons)
    );

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> status <= ST_UNSET)
        else $error("status code out of range");

    a_sums_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |-> (sum_common == '0 && sum_ch1 == '0))
        else $error("sums on rejected item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(!empty) && !$past(pop)) |-> !empty)
        else $error("result dropped while stalled");
endmodule

// ----- tb/testbench.sv -----
module testbench;
    import ppa_pkg::*;

    localparam int COLS = DEF_COLS;
    localparam int ROWS = DEF_ROWS;
    localparam int NPIX = COLS * ROWS;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] px;
        logic [31:0] py;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [15:0] ph;
    } hit_req_t;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s3;
        logic [31:0] s4;
        logic [31:0] tot;
    } tally_t;

    class image_scoreboard;
        logic [23:0] pix [NPIX];
        logic [31:0] total;
        logic [31:0] org_x, org_y, inv_w, inv_h;
        logic [1:0]  kind;
        tally_t      pending [$];
        int          errors;
        int          checked;

        function new();
            foreach (pix[i]) pix[i] = '0;
            total = 0;
            org_x = 0;
            org_y = 0;
            inv_w = 32'd65536;
            inv_h = 32'd65536;
            kind = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                CFG_ORIGIN_X: org_x = v;
                CFG_ORIGIN_Y: org_y = v;
                CFG_INV_W: inv_w = v;
                CFG_INV_H: inv_h = v;
                CFG_KIND: kind = v[1:0];
                default: ;
            endcase
        endfunction

        function bit map_axis(logic [31:0] p, logic [31:0] o, logic [31:0] inv, int lim,
                              output int idx);
            longint d;
            logic [65:0] prod;
            d = longint'($signed(p)) - longint'($signed(o));
            idx = 0;
            if (d < 0)
                return inv == 0;
            prod = 66'(d) * 66'(inv);
            if (prod[65:32] >= lim)
                return 0;
            idx = int'(prod[37:32]);
            return 1;
        endfunction

        function logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function int channel(int c, int r);
            if (((c + r) & 1) == 0)
                return 0;
            if (kind == KIND_NEUTRON)
            begin
                if (c < COLS / 2)
                    return (r < ROWS / 2) ? 1 : 3;
                return (r >= ROWS / 2) ? 4 : 2;
            end
            return (4 * c) / COLS + 1;
        endfunction

        function void note_item(hit_req_t it);
            tally_t t;
            logic [31:0] sums [5];
            bit okx, oky;
            int c, r, k;
            logic [24:0] v;
            t = '0;
            foreach (sums[j]) sums[j] = 0;
            if (it.req == REQ_ADD_POS || it.req == REQ_ADD_PIX)
            begin
                if (it.req == REQ_ADD_POS)
                begin
                    okx = map_axis(it.px, org_x, inv_w, COLS, c);
                    oky = map_axis(it.py, org_y, inv_h, ROWS, r);
                end
                else
                begin
                    c = it.col;
                    r = it.row;
                    okx = c < COLS;
                    oky = r < ROWS;
                end
                if (it.ph[15])
                    t.st = ST_NEG;
                else if (!okx)
                    t.st = ST_X_RANGE;
                else if (!oky)
                    t.st = ST_Y_RANGE;
                else
                begin
                    k = c * ROWS + r;
                    v = {1'b0, pix[k]} + 25'(it.ph);
                    pix[k] = v[24] ? 24'hFF_FFFF : v[23:0];
                    total = sat32(total, 32'(it.ph));
                end
            end
            else if (it.req == REQ_CLEAR)
            begin
                foreach (pix[i]) pix[i] = '0;
                total = 0;
            end
            else if (total != 0)
            begin
                if (kind != KIND_NEUTRON && kind != KIND_PROTON)
                    t.st = ST_UNSET;
                else
                    for (int cc = 0; cc < COLS; cc++)
                        for (int rr = 0; rr < ROWS; rr++)
                        begin
                            k = channel(cc, rr);
                            sums[k] = sat32(sums[k], 32'(pix[cc * ROWS + rr]));
                        end
            end
            t.s0 = sums[0];
            t.s1 = sums[1];
            t.s2 = sums[2];
            t.s3 = sums[3];
            t.s4 = sums[4];
            t.tot = total;
            pending.push_back(t);
        endfunction

        function void check_result(tally_t got);
            tally_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.st !== e.st) begin $error("status exp %0d got %0d", e.st, got.st); errors++; end
            if (got.s0 !== e.s0) begin $error("sum_common exp %0h got %0h", e.s0, got.s0); errors++; end
            if (got.s1 !== e.s1) begin $error("sum_ch1 exp %0h got %0h", e.s1, got.s1); errors++; end
            if (got.s2 !== e.s2) begin $error("sum_ch2 exp %0h got %0h", e.s2, got.s2); errors++; end
            if (got.s3 !== e.s3) begin $error("sum_ch3 exp %0h got %0h", e.s3, got.s3); errors++; end
            if (got.s4 !== e.s4) begin $error("sum_ch4 exp %0h got %0h", e.s4, got.s4); errors++; end
            if (got.tot !== e.tot)
            begin
                $error("total_photons exp %0h got %0h", e.tot, got.tot);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, push, full, empty, pop, wr_en;
    logic [1:0] req_type;
    logic [31:0] pos_x, pos_y;
    logic [5:0] pixel_col, pixel_row;
    logic [15:0] photons;
    logic [2:0] status;
    logic [31:0] sum_common, sum_ch1, sum_ch2, sum_ch3, sum_ch4, total_photons;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;

    image_scoreboard board;
    bit quiet_tail;
    bit hold_sink;
    int idle_cycles;
    int sent;

    photon_pixel_accumulator_core #(.COLS(COLS), .ROWS(ROWS)) dut (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            board.note_item('{req_type, pos_x, pos_y, pixel_col, pixel_row, photons});
        if (rst_n && pop && !empty)
            board.check_result('{status, sum_common, sum_ch1, sum_ch2, sum_ch3, sum_ch4,
                                 total_photons});
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // drain side: random stalls, one long hold
    initial
    begin
        int gap;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                pop <= 1'b0;
                repeat (300) @(posedge clk);
                hold_sink = 0;
            end
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 5);
                pop <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic send_item(hit_req_t it);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        {req_type, pos_x, pos_y, pixel_col, pixel_row, photons} <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= v;
        @(posedge clk);
        wr_en <= 1'b0;
        board.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic settle();
        int guard;
        push <= 1'b0;
        guard = 0;
        while (board.pending.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (2 * NPIX + 20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_pos(logic [31:0] org);
        logic [31:0] v;
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        v = $urandom_range(0, 9 * 65536);
        return org + v - 32'd32768;
    endfunction

    function automatic hit_req_t rand_item();
        hit_req_t it;
        int pick;
        it.px = rand_pos(board.org_x);
        it.py = rand_pos(board.org_y);
        it.col = ($urandom_range(0, 7) == 0) ? 6'($urandom()) : 6'($urandom_range(0, COLS - 1));
        it.row = ($urandom_range(0, 7) == 0) ? 6'($urandom()) : 6'($urandom_range(0, ROWS - 1));
        pick = $urandom_range(0, 19);
        if (pick < 2)
            it.ph = 16'($urandom());
        else if (pick < 4)
            it.ph = 16'h7FFF - 16'($urandom_range(0, 3));
        else
            it.ph = 16'($urandom_range(0, 300));
        pick = $urandom_range(0, 39);
        it.req = (pick < 18) ? REQ_ADD_POS : (pick < 35) ? REQ_ADD_PIX :
                 (pick < 36) ? REQ_CLEAR : REQ_READ;
        return it;
    endfunction

    function automatic hit_req_t mk(logic [1:0] r, logic [31:0] x, logic [31:0] y,
                                    logic [5:0] c, logic [5:0] w, logic [15:0] p);
        return '{r, x, y, c, w, p};
    endfunction

    initial
    begin
        board = new();
        rst_n = 1'b0;
        push <= 1'b0;
        wr_en <= 1'b0;
        wr_index <= '0;
        wr_data <= '0;
        {req_type, pos_x, pos_y, pixel_col, pixel_row, photons} <= '0;
        idle_cycles = 0;
        quiet_tail = 0;
        hold_sink = 0;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unset kind, extremes, checks
        send_item(mk(REQ_READ, 0, 0, 0, 0, 0));
        send_item(mk(REQ_ADD_PIX, 0, 0, 0, 0, 16'd5));
        send_item(mk(REQ_READ, 0, 0, 0, 0, 0));
        send_item(mk(REQ_ADD_PIX, 0, 0, 6'd63, 6'd63, 16'h8000));
        send_item(mk(REQ_ADD_PIX, 0, 0, 6'd63, 0, 16'd1));
        send_item(mk(REQ_ADD_PIX, 0, 0, 0, 6'd63, 16'd1));
        send_item(mk(REQ_ADD_POS, 32'h8000_0000, 0, 0, 0, 16'd1));
        send_item(mk(REQ_ADD_POS, 32'h7FFF_FFFF, 0, 0, 0, 16'd1));
        send_item(mk(REQ_ADD_POS, 0, 32'h8000_0000, 0, 0, 16'd1));
        send_item(mk(REQ_ADD_POS, 32'h0007_FFFF, 32'h0007_FFFF, 0, 0, 16'h7FFF));
        send_item(mk(REQ_ADD_POS, 32'h0008_0000, 0, 0, 0, 16'd2));
        send_item(mk(REQ_ADD_POS, 0, 0, 0, 0, 16'hFFFF));
        send_item(mk(REQ_CLEAR, 0, 0, 0, 0, 0));
        send_item(mk(REQ_READ, 0, 0, 0, 0, 0));
        settle();

        write_reg(CFG_KIND, KIND_NEUTRON);
        for (int i = 0; i < 300; i++)
            send_item(mk(REQ_ADD_PIX, 0, 0, 6'd1, 6'd2, 16'h7FFF));
        send_item(mk(REQ_READ, 0, 0, 0, 0, 0));
        for (int i = 0; i < 200; i++)
            send_item(rand_item());
        settle();

        // zero inverse: negative offsets land on pixel zero
        write_reg(CFG_ORIGIN_X, 32'h7FFF_FFFF);
        write_reg(CFG_ORIGIN_Y, 32'h8000_0000);
        write_reg(CFG_INV_W, 32'd0);
        write_reg(CFG_INV_H, 32'hFFFF_FFFF);
        write_reg(CFG_KIND, 2'd3);
        send_item(mk(REQ_ADD_POS, 32'h8000_0000, 32'h8000_0000, 0, 0, 16'd7));
        send_item(mk(REQ_ADD_POS, 32'h8000_0000, 32'h8000_0008, 0, 0, 16'd7));
        send_item(mk(REQ_ADD_POS, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 16'd7));
        for (int i = 0; i < 150; i++)
            send_item(rand_item());
        send_item(mk(REQ_READ, 0, 0, 0, 0, 0));
        settle();

        write_reg(CFG_KIND, KIND_PROTON);
        write_reg(CFG_ORIGIN_X, 32'hFFFE_0000);
        write_reg(CFG_ORIGIN_Y, 32'h0001_8000);
        write_reg(CFG_INV_W, 32'h0002_0000);
        write_reg(CFG_INV_H, 32'h0000_8000);
        hold_sink = 1;
        for (int i = 0; i < 200; i++)
            send_item(rand_item());
        settle();

        write_reg(CFG_KIND, 2'd0);
        write_reg(CFG_ORIGIN_X, $urandom());
        write_reg(CFG_ORIGIN_Y, $urandom());
        write_reg(CFG_INV_W, 32'h0001_0000);
        write_reg(CFG_INV_H, 32'h0001_0000);
        for (int i = 0; i < 100; i++)
            send_item(rand_item());
        settle();

        write_reg(CFG_KIND, KIND_NEUTRON);
        write_reg(CFG_ORIGIN_X, 32'd0);
        write_reg(CFG_ORIGIN_Y, 32'd0);
        for (int i = 0; i < 250; i++)
        begin
            if (i == 150)
                quiet_tail = 1;
            send_item(rand_item());
        end
        settle();

        $display("Sent %0d items over neutron, proton and unset layouts, %0d results checked.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
